[rtl/kcl_pkg.sv]
// Package: shared types and codes for the keypad combination lock.
`default_nettype none

package kcl_pkg;

  // Input transaction
  typedef struct packed {
    logic       action;
    logic [3:0] key_code;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [3:0] event_res;
    logic       door_open;
    logic       locked_out;
    logic [7:0] time_left;
  } out_item_t;

  // Live configuration
  typedef struct packed {
    logic [3:0] max_fails;
    logic [7:0] lockout_ticks;
    logic [7:0] unlock_ticks;
  } cfg_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_FAILS     = 2'd0;
  localparam logic [1:0] CFG_LOCKOUT_TICKS = 2'd1;
  localparam logic [1:0] CFG_UNLOCK_TICKS  = 2'd2;

  localparam logic [3:0] MAX_FAILS_RST     = 4'd3;
  localparam logic [7:0] LOCKOUT_TICKS_RST = 8'd10;
  localparam logic [7:0] UNLOCK_TICKS_RST  = 8'd4;

  // Actions
  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Keys
  localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [3:0] KEY_CLEAR      = 4'd10;
  localparam logic [3:0] KEY_ENTER      = 4'd11;

  // Entry that opens code change mode: 4, 4, 0 then enter
  localparam logic [3:0] CHG_DIGIT0 = 4'd4;
  localparam logic [3:0] CHG_DIGIT1 = 4'd4;
  localparam logic [3:0] CHG_DIGIT2 = 4'd0;
  localparam logic [3:0] CHG_LEN    = 4'd3;
  localparam logic [3:0] CODE_LEN   = 4'd4;

  // Events
  localparam logic [3:0] EV_NONE       = 4'd0;
  localparam logic [3:0] EV_ECHO       = 4'd1;
  localparam logic [3:0] EV_CLEARED    = 4'd2;
  localparam logic [3:0] EV_BAD_LEN    = 4'd3;
  localparam logic [3:0] EV_BAD_CODE   = 4'd4;
  localparam logic [3:0] EV_UNLOCKED   = 4'd5;
  localparam logic [3:0] EV_RELOCKED   = 4'd6;
  localparam logic [3:0] EV_LOCK_START = 4'd7;
  localparam logic [3:0] EV_LOCK_END   = 4'd8;
  localparam logic [3:0] EV_CHANGE     = 4'd9;
  localparam logic [3:0] EV_NEW_DIGIT  = 4'd10;
  localparam logic [3:0] EV_UPDATED    = 4'd11;
  localparam logic [3:0] EV_IGNORED    = 4'd12;

endpackage

`default_nettype wire

[rtl/kcl_cfg_regs.sv]
// Configuration registers of the keypad combination lock.
`default_nettype none

module kcl_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [7:0]   cfg_wdata,
  output kcl_pkg::cfg_t     cfg
);
  import kcl_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_fails     <= MAX_FAILS_RST;
      cfg_r.lockout_ticks <= LOCKOUT_TICKS_RST;
      cfg_r.unlock_ticks  <= UNLOCK_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_FAILS:     cfg_r.max_fails     <= cfg_wdata[3:0];
        CFG_LOCKOUT_TICKS: cfg_r.lockout_ticks <= cfg_wdata;
        CFG_UNLOCK_TICKS:  cfg_r.unlock_ticks  <= cfg_wdata;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/kcl_core.sv]
// Lock state machine: state registers and the per-transaction next-state logic.
`default_nettype none

module kcl_core #(
  parameter int ENTRY_LIMIT = 10
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          go,
  input  kcl_pkg::in_item_t  item,
  input  kcl_pkg::cfg_t      cfg,
  output kcl_pkg::out_item_t result
);
  import kcl_pkg::*;

  localparam logic [3:0] ENTRY_MAX = 4'(ENTRY_LIMIT);

  typedef enum logic [1:0] {
    MODE_ENTRY,
    MODE_CHANGE,
    MODE_OPEN,
    MODE_LOCKOUT
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [3:0] entry_digits_r [4];
  logic [3:0] entry_digits_nxt [4];
  logic [3:0] code_digits_r [4];
  logic [3:0] code_digits_nxt [4];
  logic [3:0] entry_count_r, entry_count_nxt;
  logic [3:0] fail_count_r, fail_count_nxt;
  logic [1:0] change_index_r, change_index_nxt;
  logic [7:0] timer_r, timer_nxt;
  logic [3:0] ev;
  logic [3:0] fail_inc;
  logic       code_match;
  logic       chg_entry;

  assign fail_inc   = fail_count_r + 4'd1;
  assign code_match = (entry_digits_r[0] == code_digits_r[0]) &&
                      (entry_digits_r[1] == code_digits_r[1]) &&
                      (entry_digits_r[2] == code_digits_r[2]) &&
                      (entry_digits_r[3] == code_digits_r[3]);
  assign chg_entry  = (entry_count_r == CHG_LEN) &&
                      (entry_digits_r[0] == CHG_DIGIT0) &&
                      (entry_digits_r[1] == CHG_DIGIT1) &&
                      (entry_digits_r[2] == CHG_DIGIT2);

  always_comb begin
    mode_nxt         = mode_r;
    entry_digits_nxt = entry_digits_r;
    code_digits_nxt  = code_digits_r;
    entry_count_nxt  = entry_count_r;
    fail_count_nxt   = fail_count_r;
    change_index_nxt = change_index_r;
    timer_nxt        = timer_r;
    ev               = EV_NONE;

    if (item.action == ACT_TICK) begin
      if (mode_r == MODE_OPEN || mode_r == MODE_LOCKOUT) begin
        if (timer_r > 8'd1) begin
          timer_nxt = timer_r - 8'd1;
        end else begin
          timer_nxt = 8'd0;
          mode_nxt  = MODE_ENTRY;
          ev        = (mode_r == MODE_OPEN) ? EV_RELOCKED : EV_LOCK_END;
        end
      end
    end else begin
      unique case (mode_r)
        MODE_ENTRY: begin
          if (item.key_code <= KEY_LAST_DIGIT) begin
            if (entry_count_r >= ENTRY_MAX) begin
              ev = EV_IGNORED;
            end else begin
              // only the first four digits are kept
              if (entry_count_r < CODE_LEN) begin
                entry_digits_nxt[entry_count_r[1:0]] = item.key_code;
              end
              entry_count_nxt = entry_count_r + 4'd1;
              ev = EV_ECHO;
            end
          end else if (item.key_code == KEY_CLEAR) begin
            entry_count_nxt = 4'd0;
            ev = EV_CLEARED;
          end else if (item.key_code == KEY_ENTER) begin
            entry_count_nxt = 4'd0;
            if (chg_entry) begin
              mode_nxt         = MODE_CHANGE;
              change_index_nxt = 2'd0;
              ev               = EV_CHANGE;
            end else if (entry_count_r == CODE_LEN) begin
              if (code_match) begin
                fail_count_nxt = 4'd0;
                mode_nxt       = MODE_OPEN;
                timer_nxt      = cfg.unlock_ticks;
                ev             = EV_UNLOCKED;
              end else if (fail_inc >= cfg.max_fails) begin
                fail_count_nxt = 4'd0;
                mode_nxt       = MODE_LOCKOUT;
                timer_nxt      = cfg.lockout_ticks;
                ev             = EV_LOCK_START;
              end else begin
                fail_count_nxt = fail_inc;
                ev             = EV_BAD_CODE;
              end
            end else begin
              ev = EV_BAD_LEN;
            end
          end else begin
            ev = EV_IGNORED;
          end
        end
        MODE_CHANGE: begin
          if (item.key_code > KEY_LAST_DIGIT) begin
            ev = EV_IGNORED;
          end else begin
            code_digits_nxt[change_index_r] = item.key_code;
            if (change_index_r == 2'd3) begin
              change_index_nxt = 2'd0;
              mode_nxt         = MODE_ENTRY;
              ev               = EV_UPDATED;
            end else begin
              change_index_nxt = change_index_r + 2'd1;
              ev               = EV_NEW_DIGIT;
            end
          end
        end
        default: ev = EV_IGNORED; // unlocked or locked out
      endcase
    end
  end

  always_comb begin
    result.event_res  = ev;
    result.door_open  = (mode_nxt == MODE_OPEN);
    result.locked_out = (mode_nxt == MODE_LOCKOUT);
    result.time_left  = (mode_nxt == MODE_OPEN || mode_nxt == MODE_LOCKOUT) ?
                        timer_nxt : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r            <= MODE_ENTRY;
      entry_digits_r    <= '{4'd0, 4'd0, 4'd0, 4'd0};
      code_digits_r     <= '{4'd1, 4'd2, 4'd3, 4'd4};
      entry_count_r     <= 4'd0;
      fail_count_r      <= 4'd0;
      change_index_r    <= 2'd0;
      timer_r           <= 8'd0;
    end else if (go) begin
      mode_r            <= mode_nxt;
      entry_digits_r    <= entry_digits_nxt;
      code_digits_r     <= code_digits_nxt;
      entry_count_r     <= entry_count_nxt;
      fail_count_r      <= fail_count_nxt;
      change_index_r    <= change_index_nxt;
      timer_r           <= timer_nxt;
    end
  end

  a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= ENTRY_MAX)
    else $error("entry count past limit");

  a_lock_clears_fails: assert property (@(posedge clk) disable iff (!rst_n)
    go && ev == EV_LOCK_START |=> fail_count_r == 4'd0 && mode_r == MODE_LOCKOUT)
    else $error("lockout start did not clear failures");

  a_idle_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
    go && item.action == ACT_TICK && (mode_r == MODE_ENTRY || mode_r == MODE_CHANGE)
    |=> $stable(entry_count_r) && $stable(mode_r) && $stable(fail_count_r))
    else $error("tick changed state outside a timed interval");

endmodule

`default_nettype wire

[rtl/keypad_combination_lock_unit.sv]
// Top level of the keypad combination lock: input register, lock core, result register.
// Two register stages: a transaction in the input register passes the lock core into the
// result register that drives out_valid, waiting while out_stall holds the result.
// Throughput: one transaction per cycle when out_stall is low; the result register frees
// the input side whenever the result is taken or the output is empty.
// Reset (rst_n low, synchronous): both channels empty, code 1-2-3-4, entry mode,
// counts and timer zero, max_fails 3, lockout_ticks 10, unlock_ticks 4.
`default_nettype none

module keypad_combination_lock_unit #(
  parameter int ENTRY_LIMIT = 10
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  kcl_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output kcl_pkg::out_item_t  out_data,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [7:0]     cfg_wdata
);
  import kcl_pkg::*;

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t result;
  cfg_t      cfg;
  logic      go;

  // advance the held transaction when the result register is free
  assign go       = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !go;

  kcl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kcl_core #(
    .ENTRY_LIMIT (ENTRY_LIMIT)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_data;
    end
    if (go) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_go_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid_r)
    else $error("processed transaction did not reach result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !go)
    else $error("result overwritten while stalled");

  a_held_item_stable: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !go |=> in_valid_r && $stable(in_item_r))
    else $error("held input transaction changed while waiting");

endmodule

`default_nettype wire
